// ----- rtl/linear_probe_hash_set_macros.svh -----
// Assertion macros used by the hash set RTL.
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH

// Property checked outside reset.
`define LPHS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LPHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lphs_pkg.sv -----
// Shared constants, codes and beat types of the hash set.
`timescale 1ns / 1ps
`default_nettype none

package lphs_pkg;

  localparam int CAPACITY   = 1024;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int KEY_W      = 31;
  localparam int SIZE_W     = 11;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = KEY_W + 1;
  localparam int MOD_CNT_W  = $clog2(KEY_W + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    stored_key;
    logic                occupied;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/linear_probe_hash_set.sv -----
// Linear-probing hash set: command sequencer, slot RAM and bit-serial modulo unit.
// Insert/lookup: a bit-serial modulo in S_MOD over the 31 key bits, then S_RD and S_CHK
// for each slot probed; read slot: S_RD then S_CHK; unknown command: NOT_FOUND, no RAM access.
// One command in flight: busy is high until done, and the next start is taken while done is high.
// Results are a one-cycle done strobe the receiver cannot stall; config always ready.
// Reset: table_size back to 1024, then a RAM clearing pass over all 1024 slots with busy high.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_set (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire lphs_pkg::cmd_t            cmd,
  output logic                           done,
  output lphs_pkg::result_t              result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [lphs_pkg::SIZE_W-1:0] cfg_data
);

  import lphs_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_RD    = 5'b01000,
    S_CHK   = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] n_eff;
  logic [SLOT_W-1:0] clr_addr, clr_addr_next;
  logic              done_next;
  result_t           res_next;
  logic [SLOT_W-1:0] pos, pos_next;
  logic [SIZE_W-1:0] probes, probes_next;
  logic [SIZE_W-1:0] n_q, n_next;
  cmd_t              cmd_q, cmd_next;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               mod_go;
  logic               mod_done;
  logic [SLOT_W-1:0]  mod_rem;

  logic              ent_used;
  logic [KEY_W-1:0]  ent_key;
  logic              last_probe;
  logic [SIZE_W-1:0] pos_inc;

  logic              take_work;
  logic              chk_write;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  always_comb begin
    if (table_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (table_size > SIZE_W'(CAPACITY)) begin
      n_eff = SIZE_W'(CAPACITY);
    end else begin
      n_eff = table_size;
    end
  end

  lphs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  lphs_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .go        (mod_go),
    .dividend  (cmd.key),
    .divisor   (n_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign ent_used   = ram_rdata[KEY_W];
  assign ent_key    = ram_rdata[KEY_W-1:0];
  assign last_probe = (probes + 1'b1) == n_q;
  assign pos_inc    = {1'b0, pos} + 1'b1;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    res_next      = result;
    pos_next      = pos;
    probes_next   = probes;
    n_next        = n_q;
    cmd_next      = cmd_q;
    ram_we        = 1'b0;
    ram_waddr     = pos;
    ram_wdata     = '0;
    mod_go        = 1'b0;

    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == SLOT_W'(CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_next    = cmd;
          n_next      = n_eff;
          probes_next = '0;
          case (cmd.command)
            CMD_INSERT, CMD_LOOKUP: begin
              mod_go     = 1'b1;
              state_next = S_MOD;
            end
            CMD_READ: begin
              pos_next   = cmd.slot_index;
              state_next = S_RD;
            end
            default: begin
              res_next  = '{status: ST_NOT_FOUND, slot: '0, stored_key: '0, occupied: 1'b0};
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_next   = mod_rem;
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        // default: step to the next slot, wrapping at the table size
        state_next  = S_RD;
        probes_next = probes + 1'b1;
        pos_next    = (pos_inc == n_q) ? '0 : pos_inc[SLOT_W-1:0];
        case (cmd_q.command)
          CMD_INSERT: begin
            if (!ent_used) begin
              ram_we     = 1'b1;
              ram_wdata  = {1'b1, cmd_q.key};
              res_next   = '{status: ST_INSERTED, slot: pos, stored_key: cmd_q.key,
                             occupied: 1'b1};
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (last_probe) begin
              res_next   = '{status: ST_FULL, slot: '0, stored_key: '0, occupied: 1'b0};
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_LOOKUP: begin
            if (ent_used && ent_key == cmd_q.key) begin
              res_next   = '{status: ST_FOUND, slot: pos, stored_key: cmd_q.key,
                             occupied: 1'b1};
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (!ent_used || last_probe) begin
              res_next   = '{status: ST_NOT_FOUND, slot: '0, stored_key: '0,
                             occupied: 1'b0};
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            res_next   = '{status: ST_READ, slot: pos,
                           stored_key: ent_used ? ent_key : '0, occupied: ent_used};
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      done       <= 1'b0;
      table_size <= SIZE_RESET;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    pos    <= pos_next;
    probes <= probes_next;
    n_q    <= n_next;
    cmd_q  <= cmd_next;
  end

  assign take_work = start && !busy && (cmd.command inside {CMD_INSERT, CMD_LOOKUP, CMD_READ});
  assign chk_write = ram_we && (state == S_CHK);

  `include "linear_probe_hash_set_macros.svh"

  `LPHS_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> busy, "clearing pass not started")
  `LPHS_ASSERT(a_done_frees, clk, rst, done |-> !busy, "done beat while still busy")
  `LPHS_ASSERT(a_work_busy, clk, rst, take_work |=> busy && !done, "busy not held")
  `LPHS_ASSERT(a_insert_empty_only, clk, rst, chk_write |-> !ent_used, "slot overwritten")

endmodule

`default_nettype wire

// ----- rtl/lphs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/lphs_mod.sv -----
// Bit-serial restoring remainder unit: key modulo table size, one key bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lphs_mod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      go,
  input  wire logic [lphs_pkg::KEY_W-1:0]  dividend,
  input  wire logic [lphs_pkg::SIZE_W-1:0] divisor,
  output logic                           done,
  output logic [lphs_pkg::SLOT_W-1:0]    remainder
);

  import lphs_pkg::*;

  logic                 running;
  logic [MOD_CNT_W-1:0] cnt;
  logic [SIZE_W-1:0]    rem;
  logic [KEY_W-1:0]     sh;
  logic [SIZE_W-1:0]    dvs;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic [SIZE_W-1:0]    rem_next;

  assign trial    = {rem, sh[KEY_W-1]};
  assign diff     = trial - {1'b0, dvs};
  // remainder stays below the divisor, so it fits the narrower width
  assign rem_next = (trial >= {1'b0, dvs}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
  assign remainder = rem[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= MOD_CNT_W'(KEY_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == MOD_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      sh  <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem <= rem_next;
      sh  <= {sh[KEY_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire
